### design/swmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmr_pkg: shared constants for the sliding-window range unit
// Defaults for the top-level parameters, register map and state codes.
// ----------------------------------------------------------------------------
package swmr_pkg;

  localparam int MAX_WINDOW_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // configuration register map
  localparam int SPAN_BITS = 6;
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam logic [0:0] REG_WINDOW_SPAN = 1'b0;

  // control states of the top level
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LAUNCH = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;

endpackage : swmr_pkg
`default_nettype wire

### design/swmr_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmr_cell: one window position of the sample chain
// Holds one sample, shifted in from the newer neighbor. A scan token that
// carries the running min and max walks toward the newest cell, folding in
// the sample of each cell it passes.
// ----------------------------------------------------------------------------
module swmr_cell
  import swmr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   shift,
  input  wire logic [SAMPLE_BITS-1:0] smp_in,
  output logic      [SAMPLE_BITS-1:0] smp_out,
  input  wire logic                   inject,
  input  wire logic                   tok_vin,
  input  wire logic [SAMPLE_BITS-1:0] tok_lo_in,
  input  wire logic [SAMPLE_BITS-1:0] tok_hi_in,
  output logic                        tok_vout,
  output logic      [SAMPLE_BITS-1:0] tok_lo_out,
  output logic      [SAMPLE_BITS-1:0] tok_hi_out
);

  logic [SAMPLE_BITS-1:0] smp;
  logic                   tok_v;
  logic [SAMPLE_BITS-1:0] tok_lo;
  logic [SAMPLE_BITS-1:0] tok_hi;
  logic [SAMPLE_BITS-1:0] lo_src;
  logic [SAMPLE_BITS-1:0] hi_src;
  logic [SAMPLE_BITS-1:0] tok_lo_next;
  logic [SAMPLE_BITS-1:0] tok_hi_next;

  // an injected token starts from the identity of min and max
  assign lo_src      = inject ? '1 : tok_lo_in;
  assign hi_src      = inject ? '0 : tok_hi_in;
  assign tok_lo_next = (smp < lo_src) ? smp : lo_src;
  assign tok_hi_next = (smp > hi_src) ? smp : hi_src;

  always_ff @(posedge clk) begin
    if (shift) begin
      smp <= smp_in;
    end
    tok_lo <= tok_lo_next;
    tok_hi <= tok_hi_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_v <= 1'b0;
    end else begin
      tok_v <= inject | tok_vin;
    end
  end

  assign smp_out    = smp;
  assign tok_vout   = tok_v;
  assign tok_lo_out = tok_lo;
  assign tok_hi_out = tok_hi;

endmodule : swmr_cell
`default_nettype wire

### design/sliding_window_max_range_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_max_range_unit: sliding-window range and best-range tracker
// Keeps the newest samples in a chain of cells, forms max minus min over the
// configured window and tracks the largest full-window range of a sequence.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  -------   ---------          -------
//  input     in_valid/in_ready  sample, start_req
//  output    out_valid/out_ready window_range, window_full, best_range
//  config    APB psel/penable   paddr, pwdata, prdata (window_span at 0x0)
//
//  A transaction whose window is not yet full goes from IDLE through LAUNCH
//  back to IDLE; a full window also passes through SCAN, whose length is
//  set by the scan token walking from the oldest window cell to cell 0.
//  rst is synchronous and clears control state, fill count and best range.
//  A stalled output holds its transaction; the scan waits to launch until the
//  output register is free, and the input accepts while a result waits.
// ----------------------------------------------------------------------------
module sliding_window_max_range_unit
  import swmr_pkg::*;
#(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [APB_AW-1:0]      paddr,
  input  wire logic [APB_DW-1:0]      pwdata,
  output logic      [APB_DW-1:0]      prdata,
  output logic                        pready,
  // input stream
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic                   start_req,
  // output stream
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [SAMPLE_BITS-1:0] window_range,
  output logic                        window_full,
  output logic      [SAMPLE_BITS-1:0] best_range
);

  localparam int IDXW = $clog2(MAX_WINDOW);
  localparam int CNTW = $clog2(MAX_WINDOW + 1);
  localparam logic [IDXW-1:0] LAST_MAX = IDXW'(MAX_WINDOW - 1);
  localparam logic [CNTW-1:0] FILL_MAX = CNTW'(MAX_WINDOW);
  localparam logic [MAX_WINDOW-1:0] ONE_HOT0 = MAX_WINDOW'(1);

  logic [SPAN_BITS-1:0]   window_span;
  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [CNTW-1:0]        fill;
  logic [CNTW-1:0]        fill_base;
  logic [SAMPLE_BITS-1:0] best;
  logic [SAMPLE_BITS-1:0] best_next;
  logic [SAMPLE_BITS-1:0] range;
  logic [IDXW-1:0]        last_idx;
  logic                   full;
  logic                   in_acc;
  logic                   out_free;
  logic                   launch;
  logic                   load_empty;
  logic                   load_full;
  logic                   cfg_wr;
  logic [MAX_WINDOW-1:0]  inj_vec;

  // chain wiring: index k is the k-th newest sample
  logic [SAMPLE_BITS-1:0] smp_w  [MAX_WINDOW];
  logic                   tv_w   [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] tlo_w  [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] thi_w  [MAX_WINDOW];

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[APB_AW-1:2] == REG_WINDOW_SPAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_span <= '0;
    end else if (cfg_wr) begin
      window_span <= pwdata[SPAN_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[APB_AW-1:2] == REG_WINDOW_SPAN) begin
      prdata = APB_DW'(window_span);
    end
  end

  // --------------------------------------------------------------- control
  // clamp the window to the chain length
  always_comb begin
    if (32'(window_span) >= 32'(MAX_WINDOW - 1)) begin
      last_idx = LAST_MAX;
    end else begin
      last_idx = IDXW'(window_span);
    end
  end

  assign full      = fill > CNTW'(last_idx);
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign fill_base = start_req ? '0 : fill;

  assign range     = thi_w[0] - tlo_w[0];
  assign best_next = (range > best) ? range : best;

  always_comb begin
    state_next = state;
    launch     = 1'b0;
    load_empty = 1'b0;
    load_full  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        if (out_free) begin
          if (full) begin
            launch     = 1'b1;
            state_next = ST_SCAN;
          end else begin
            load_empty = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        if (tv_w[0]) begin
          load_full  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign inj_vec = launch ? (ONE_HOT0 << last_idx) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      best  <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        fill <= (fill_base < FILL_MAX) ? fill_base + 1'b1 : fill_base;
        if (start_req) begin
          best <= '0;
        end
      end else if (load_full) begin
        best <= best_next;
      end
    end
  end

  // --------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_empty || load_full) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_empty) begin
      window_range <= '0;
      window_full  <= 1'b0;
      best_range   <= best;
    end else if (load_full) begin
      window_range <= range;
      window_full  <= 1'b1;
      best_range   <= best_next;
    end
  end

  // ------------------------------------------------------------ cell chain
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    logic [SAMPLE_BITS-1:0] smp_src;
    logic                   tv_src;
    logic [SAMPLE_BITS-1:0] tlo_src;
    logic [SAMPLE_BITS-1:0] thi_src;

    if (k == 0) begin : g_head
      assign smp_src = sample;
    end else begin : g_body
      assign smp_src = smp_w[k-1];
    end

    // tokens walk from older cells toward cell 0
    if (k == MAX_WINDOW - 1) begin : g_tail
      assign tv_src  = 1'b0;
      assign tlo_src = '1;
      assign thi_src = '0;
    end else begin : g_link
      assign tv_src  = tv_w[k+1];
      assign tlo_src = tlo_w[k+1];
      assign thi_src = thi_w[k+1];
    end

    swmr_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (in_acc),
      .smp_in     (smp_src),
      .smp_out    (smp_w[k]),
      .inject     (inj_vec[k]),
      .tok_vin    (tv_src),
      .tok_lo_in  (tlo_src),
      .tok_hi_in  (thi_src),
      .tok_vout   (tv_w[k]),
      .tok_lo_out (tlo_w[k]),
      .tok_hi_out (thi_w[k])
    );
  end

endmodule : sliding_window_max_range_unit
`default_nettype wire

### design/swmr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swmr_checker: port-level checks for the sliding-window range unit
// Watches the output channel of the top level over time.
// ----------------------------------------------------------------------------
module swmr_checker
  import swmr_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   start_req,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [SAMPLE_BITS-1:0] window_range,
  input wire logic                   window_full,
  input wire logic [SAMPLE_BITS-1:0] best_range
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // no full window, no range
  a_empty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !window_full |-> window_range == '0)
    else $error("nonzero range without a full window");

  // best range covers the current one
  a_best_covers: assert property (@(posedge clk) disable iff (rst)
    out_valid && window_full |-> best_range >= window_range)
    else $error("best range below window range");

  // a new sequence cannot yield a result in the next cycle
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && start_req && !out_valid |=> !out_valid)
    else $error("result appeared one cycle after accept");

endmodule : swmr_checker

bind sliding_window_max_range_unit swmr_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_swmr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .start_req    (start_req),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .window_range (window_range),
  .window_full  (window_full),
  .best_range   (best_range)
);
`default_nettype wire
